// File: rtl/khe_pkg.sv
// ----------------------------------------------------------------------------
// khe_pkg
// Shared types and constants of the knot hash engine: item structs, the
// controller state enum, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package khe_pkg;

  localparam int unsigned SUFFIX_LEN = 5;
  localparam int unsigned GROUP_LEN  = 16;
  localparam int unsigned DIGEST_LEN = 16;

  localparam logic [6:0] ROUNDS_MAX    = 7'd64;
  localparam logic [6:0] ROUNDS_RESET  = 7'd64;
  localparam logic [2:0] SUFFIX_LAST   = 3'(SUFFIX_LEN - 1);
  localparam logic [3:0] GROUP_LAST    = 4'(GROUP_LEN - 1);
  localparam logic [7:0] FOLD_LAST     = 8'(GROUP_LEN * DIGEST_LEN - 1);

  typedef struct packed {
    logic [7:0] length_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] hash_byte;
    logic [3:0] byte_index;
    logic       digest_end;
    logic       overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SETUP,
    ST_SWAP_RD,
    ST_WR_A,
    ST_WR_B,
    ST_ADVANCE,
    ST_FOLD_RD,
    ST_FOLD_ACC
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic fetch;
    logic setup;
    logic swap_rd;
    logic wr_a;
    logic wr_b;
    logic advance;
    logic fold_rd;
    logic fold_acc;
    logic restart;
  } dp_cmd_t;

  typedef struct packed {
    logic swaps_zero;
    logic seq_end;
    logic group_end;
    logic digest_end;
    logic out_busy;
  } dp_status_t;

  function automatic logic [7:0] suffix_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'd17;
      3'd1:    val = 8'd31;
      3'd2:    val = 8'd73;
      3'd3:    val = 8'd47;
      3'd4:    val = 8'd23;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/khe_ctrl.sv
// ----------------------------------------------------------------------------
// khe_ctrl
// Sequencer of the knot hash engine: loads message bytes, steps each twist
// through fetch, setup and swap cycles, then walks the XOR fold.
// ----------------------------------------------------------------------------
module khe_ctrl import khe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_SWAP_RD;
      end
      ST_SWAP_RD: begin
        if (status_i.swaps_zero) begin
          state_d = ST_ADVANCE;
        end else begin
          cmd_o.swap_rd = 1'b1;
          state_d       = ST_WR_A;
        end
      end
      ST_WR_A: begin
        cmd_o.wr_a = 1'b1;
        state_d    = ST_WR_B;
      end
      ST_WR_B: begin
        cmd_o.wr_b = 1'b1;
        state_d    = ST_SWAP_RD;
      end
      ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        state_d       = status_i.seq_end ? ST_FOLD_RD : ST_FETCH;
      end
      ST_FOLD_RD: begin
        if (!status_i.out_busy) begin
          cmd_o.fold_rd = 1'b1;
          state_d       = ST_FOLD_ACC;
        end
      end
      ST_FOLD_ACC: begin
        cmd_o.fold_acc = 1'b1;
        if (status_i.digest_end) begin
          cmd_o.restart = 1'b1;
          state_d       = ST_LOAD;
        end else begin
          state_d = ST_FOLD_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/khe_datapath.sv
// ----------------------------------------------------------------------------
// khe_datapath
// Length store, ring memory with per-entry valid bits, twist pointers,
// position and skip, fold accumulator and the output register.
// ----------------------------------------------------------------------------
module khe_datapath import khe_pkg::*; #(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned RING_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_data_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  localparam int unsigned RW = $clog2(RING_SIZE);
  localparam int unsigned LW = $clog2(RING_SIZE + 1);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [LW-1:0] RING_L    = LW'(RING_SIZE);
  localparam logic [LW:0]   RING_X    = (LW+1)'(RING_SIZE);
  localparam logic [RW:0]   RING_R    = (RW+1)'(RING_SIZE);
  localparam logic [RW-1:0] RING_LAST = RW'(RING_SIZE - 1);
  localparam logic [8:0]    RING_9    = 9'(RING_SIZE);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LEN);

  logic [7:0]  store_mem [MAX_LEN];
  logic [7:0]  store_rd_q;
  logic [7:0]  ring_mem [RING_SIZE];

  logic [RING_SIZE-1:0] vld_q;
  logic [CW-1:0] cnt_q, li_q;
  logic          ovf_q, sfx_q;
  logic [2:0]    si_q;
  logic [6:0]    rnd_q, rounds_q;
  logic [RW-1:0] pos_q, skip_q, pa_q, pb_q, lenm_q;
  logic [LW-1:0] swaps_q;
  logic [7:0]    fidx_q, acc_q;
  logic          out_vld_q;
  out_item_t     out_q;

  logic [7:0]    ra_data_q, rb_data_q;
  logic [RW-1:0] ra_addr_q, rb_addr_q;
  logic          ra_vld_q, rb_vld_q, ra_in_q;

  logic          full;
  logic [6:0]    rounds_eff;
  logic [7:0]    len8;
  logic [LW-1:0] lenc;
  logic [LW:0]   pb_sum;
  logic [RW-1:0] pb_start, lenm_d;
  logic [RW:0]   adv_s1, adv_s2;
  logic [RW-1:0] adv_p1, pos_d, skip_d;
  logic [RW-1:0] pa_next, pb_next;
  logic [RW-1:0] rd_addr_a, wr_addr;
  logic [7:0]    ra_val, rb_val, wr_data, fold_val, acc_x;
  logic          fold_in;
  logic          wr_en;

  assign full = (cnt_q == COUNT_MAX);

  always_comb begin
    if (rounds_q == 7'd0) begin
      rounds_eff = 7'd1;
    end else if (rounds_q > ROUNDS_MAX) begin
      rounds_eff = ROUNDS_MAX;
    end else begin
      rounds_eff = rounds_q;
    end
  end

  // Twist setup: clamp length, far pointer, length mod ring
  assign len8     = sfx_q ? suffix_byte(si_q) : store_rd_q;
  assign lenc     = ({1'b0, len8} > RING_9) ? RING_L : LW'(len8);
  assign pb_sum   = (LW+1)'(pos_q) + (LW+1)'(lenc) - (LW+1)'(1);
  assign pb_start = (pb_sum >= RING_X) ? RW'(pb_sum - RING_X) : RW'(pb_sum);
  assign lenm_d   = (lenc == RING_L) ? '0 : RW'(lenc);

  // Position and skip update
  assign adv_s1 = (RW+1)'(pos_q) + (RW+1)'(lenm_q);
  assign adv_p1 = (adv_s1 >= RING_R) ? RW'(adv_s1 - RING_R) : RW'(adv_s1);
  assign adv_s2 = (RW+1)'(adv_p1) + (RW+1)'(skip_q);
  assign pos_d  = (adv_s2 >= RING_R) ? RW'(adv_s2 - RING_R) : RW'(adv_s2);
  assign skip_d = (skip_q == RING_LAST) ? '0 : skip_q + RW'(1);

  assign pa_next = (pa_q == RING_LAST) ? '0 : pa_q + RW'(1);
  assign pb_next = (pb_q == '0) ? RING_LAST : pb_q - RW'(1);

  // Ring access
  assign rd_addr_a = cmd_i.fold_rd ? RW'(fidx_q) : pa_q;
  assign ra_val    = ra_vld_q ? ra_data_q : 8'(ra_addr_q);
  assign rb_val    = rb_vld_q ? rb_data_q : 8'(rb_addr_q);
  assign wr_en     = cmd_i.wr_a | cmd_i.wr_b;
  assign wr_addr   = cmd_i.wr_a ? pa_q : pb_q;
  assign wr_data   = cmd_i.wr_a ? rb_val : ra_val;
  assign fold_in   = ({1'b0, fidx_q} < RING_9);
  assign fold_val  = ra_in_q ? ra_val : 8'h00;
  assign acc_x     = acc_q ^ fold_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      store_mem[cnt_q[AW-1:0]] <= in_data_i.length_byte;
    end
    if (cmd_i.fetch) begin
      store_rd_q <= store_mem[li_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.swap_rd || cmd_i.fold_rd) begin
      ra_data_q <= ring_mem[rd_addr_a];
      ra_addr_q <= rd_addr_a;
      ra_vld_q  <= vld_q[rd_addr_a];
      ra_in_q   <= cmd_i.fold_rd ? fold_in : 1'b1;
      rb_data_q <= ring_mem[pb_q];
      rb_addr_q <= pb_q;
      rb_vld_q  <= vld_q[pb_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      cnt_q     <= '0;
      li_q      <= '0;
      ovf_q     <= 1'b0;
      sfx_q     <= 1'b0;
      si_q      <= '0;
      rnd_q     <= 7'd1;
      rounds_q  <= ROUNDS_RESET;
      pos_q     <= '0;
      skip_q    <= '0;
      pa_q      <= '0;
      pb_q      <= '0;
      lenm_q    <= '0;
      swaps_q   <= '0;
      fidx_q    <= '0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        rounds_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.setup) begin
        pa_q    <= pos_q;
        pb_q    <= pb_start;
        lenm_q  <= lenm_d;
        swaps_q <= lenc >> 1;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.wr_b) begin
        pa_q    <= pa_next;
        pb_q    <= pb_next;
        swaps_q <= swaps_q - LW'(1);
      end
      if (cmd_i.advance) begin
        pos_q  <= pos_d;
        skip_q <= skip_d;
        if (!sfx_q) begin
          if ((li_q + CW'(1)) == cnt_q) begin
            sfx_q <= 1'b1;
            si_q  <= '0;
          end else begin
            li_q <= li_q + CW'(1);
          end
        end else if (si_q == SUFFIX_LAST) begin
          sfx_q <= 1'b0;
          si_q  <= '0;
          li_q  <= '0;
          rnd_q <= rnd_q + 7'd1;
        end else begin
          si_q <= si_q + 3'd1;
        end
      end
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.fold_acc) begin
        fidx_q <= fidx_q + 8'd1;
        if (fidx_q[3:0] == GROUP_LAST) begin
          acc_q            <= '0;
          out_vld_q        <= 1'b1;
          out_q.hash_byte  <= acc_x;
          out_q.byte_index <= fidx_q[7:4];
          out_q.digest_end <= (fidx_q == FOLD_LAST);
          out_q.overflow   <= ovf_q;
        end else begin
          acc_q <= acc_x;
        end
      end
      if (cmd_i.restart) begin
        vld_q  <= '0;
        cnt_q  <= '0;
        li_q   <= '0;
        ovf_q  <= 1'b0;
        sfx_q  <= 1'b0;
        si_q   <= '0;
        rnd_q  <= 7'd1;
        pos_q  <= '0;
        skip_q <= '0;
      end
    end
  end

  assign status_o.swaps_zero = (swaps_q == '0);
  assign status_o.seq_end    = sfx_q && (si_q == SUFFIX_LAST) && (rnd_q == rounds_eff);
  assign status_o.group_end  = (fidx_q[3:0] == GROUP_LAST);
  assign status_o.digest_end = (fidx_q == FOLD_LAST);
  assign status_o.out_busy   = out_vld_q;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/knot_hash_engine_core.sv
// ----------------------------------------------------------------------------
// knot_hash_engine_core
// Knot hash over a byte message: reversal twists on a ring, XOR-folded into a
// 16-byte dense digest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one message byte per item,
//   accepted one per cycle while loading. Up to MAX_LEN bytes are kept; later
//   bytes are dropped and flag overflow on every digest byte. The item with
//   last set starts the hash and closes input until the digest is out.
//   Output channel (out_valid_o/out_ready_i/out_data_o): 16 items, byte_index
//   0 to 15, digest_end on the last one.
//   Config: cfg_we_i writes round_count (0 acts as 1, above 64 as 64).
//   After the last byte: each round runs one twist per length (message bytes
//   plus the five suffix bytes) through fetch, setup, the swaps and advance;
//   one swap takes read, write, write, as the ring memory has a single write
//   port. The fold then reads and accumulates each ring position in turn.
//   A stalled receiver holds the fold; the final digest byte sits in the
//   output register while the next message is already being loaded.
//   Reset: ring back to identity at once (valid bits), counters cleared,
//   round_count back to 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
module knot_hash_engine_core import khe_pkg::*; #(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned RING_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  khe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  khe_datapath #(
    .MAX_LEN   (MAX_LEN),
    .RING_SIZE (RING_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/khe_checker.sv
// ----------------------------------------------------------------------------
// khe_checker
// Port-level checks of the knot hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module khe_checker import khe_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.digest_end == (out_data_o.byte_index == 4'd15)))
    else $error("digest_end does not match byte_index");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> !in_ready_o)
    else $error("input still open after last byte");

  a_fold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.digest_end |=> !in_ready_o)
    else $error("input open in the middle of a digest");

endmodule

bind knot_hash_engine_core khe_checker u_khe_checker (.*);

// File: tb/knot_hash_checker.sv
// ----------------------------------------------------------------------------
// knot_hash_checker
// Watches the byte, digest and round-count ports of the knot hash engine.
// Keeps its own copy of the message and the round count, computes the 16-byte
// dense digest when a message closes, and compares every digest byte that
// leaves the block, field by field, in order.
// ----------------------------------------------------------------------------
module knot_hash_checker import khe_pkg::*; #(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned RING_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_data_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [8*SUFFIX_LEN-1:0] TAIL_LENS = {8'd17, 8'd31, 8'd73, 8'd47, 8'd23};

  logic [6:0] round_reg;
  bit   [7:0] msg_bytes [$];
  bit         drop_seen;
  out_item_t  digest_q [$];
  out_item_t  want;

  function automatic void predict_digest();
    bit [7:0]  ring [RING_SIZE];
    bit [7:0]  lens [$];
    bit [7:0]  tmp;
    bit [7:0]  acc;
    int        rounds;
    int        pos;
    int        skp;
    int        n;
    int        a;
    int        b;
    out_item_t item;
    rounds = int'(round_reg);
    if (rounds < 1) rounds = 1;
    if (rounds > int'(ROUNDS_MAX)) rounds = int'(ROUNDS_MAX);
    for (int i = 0; i < RING_SIZE; i++) ring[i] = 8'(i);
    lens = msg_bytes;
    for (int i = 0; i < SUFFIX_LEN; i++) begin
      lens.push_back(TAIL_LENS[8*(SUFFIX_LEN-1-i) +: 8]);
    end
    pos = 0;
    skp = 0;
    for (int r = 0; r < rounds; r++) begin
      foreach (lens[i]) begin
        n = int'(lens[i]);
        if (n > RING_SIZE) n = RING_SIZE;
        for (int j = 0; j < n / 2; j++) begin
          a = (pos + j) % RING_SIZE;
          b = (pos + n - 1 - j) % RING_SIZE;
          tmp = ring[a];
          ring[a] = ring[b];
          ring[b] = tmp;
        end
        pos = (pos + (n % RING_SIZE) + skp) % RING_SIZE;
        skp = (skp + 1) % RING_SIZE;
      end
    end
    for (int k = 0; k < DIGEST_LEN; k++) begin
      acc = '0;
      for (int i = 0; i < GROUP_LEN; i++) begin
        if (k * GROUP_LEN + i < RING_SIZE) acc ^= ring[k * GROUP_LEN + i];
      end
      item.hash_byte  = acc;
      item.byte_index = 4'(k);
      item.digest_end = (k == DIGEST_LEN - 1);
      item.overflow   = drop_seen;
      digest_q.push_back(item);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_reg    = ROUNDS_RESET;
      drop_seen    = 1'b0;
      msg_bytes.delete();
      digest_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest byte: hash_byte %0h byte_index %0d",
                 out_data_i.hash_byte, out_data_i.byte_index);
          fail_count_o++;
        end else begin
          want = digest_q.pop_front();
          if (out_data_i.hash_byte !== want.hash_byte) begin
            $error("hash_byte: expected %0h, actual %0h", want.hash_byte,
                   out_data_i.hash_byte);
            fail_count_o++;
          end
          if (out_data_i.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, actual %0d", want.byte_index,
                   out_data_i.byte_index);
            fail_count_o++;
          end
          if (out_data_i.digest_end !== want.digest_end) begin
            $error("digest_end: expected %0b, actual %0b", want.digest_end,
                   out_data_i.digest_end);
            fail_count_o++;
          end
          if (out_data_i.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow,
                   out_data_i.overflow);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (msg_bytes.size() < MAX_LEN) begin
          msg_bytes.push_back(in_data_i.length_byte);
        end else begin
          drop_seen = 1'b1;
        end
        if (in_data_i.last) begin
          predict_digest();
          msg_bytes.delete();
          drop_seen = 1'b0;
        end
      end
      if (cfg_we_i) round_reg = cfg_wdata_i;
      pending_o = digest_q.size();
    end
  end

endmodule

// File: tb/tb_knot_hash_engine_core.sv
// ----------------------------------------------------------------------------
// tb_knot_hash_engine_core
// Drives messages into the knot hash engine under several round counts,
// including the clamped extremes, with random gaps on the byte channel and
// random stalls on the digest channel; the checker beside the block predicts
// and compares every digest byte.
// ----------------------------------------------------------------------------
module tb_knot_hash_engine_core import khe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRESSURE_HOLD = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 100;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;
  int         fail_count;
  int         pending;
  bit         hold_req;

  knot_hash_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  knot_hash_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 35) return 8'($urandom_range(1, 16));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{length_byte: b, last: l};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rounds(input logic [6:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] rounds, input int budget, input bit heavy,
                           input bit force_long);
    int  sent;
    int  n;
    int  r;
    bit  calm;
    sent = 0;
    write_rounds(rounds);
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (heavy) n = $urandom_range(1, 3);
      else if (force_long && sent == 0) n = $urandom_range(65, 70);
      else if (r < 80) n = $urandom_range(1, 8);
      else if (r < 95) n = $urandom_range(9, 40);
      else n = $urandom_range(62, 70);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) send_byte(pick_length(), i == n - 1, calm);
      sent += n;
    end
    settle();
  endtask

  // digest receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int r;
    int hold_left;
    int stall_left;
    int calm_left;
    logic ready_next;
    hold_left   = 0;
    stall_left  = 0;
    calm_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        ready_next = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        ready_next = 1'b1;
        if (r < 8) begin
          stall_left = $urandom_range(0, 2);
          ready_next = 1'b0;
        end else if (r < 10) begin
          stall_left = $urandom_range(15, 120);
          ready_next = 1'b0;
        end else if (r < 13) begin
          calm_left = $urandom_range(40, 300);
        end
      end
      out_ready_i <= ready_next;
    end
  end

  initial begin
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default round count, single-byte messages at both length extremes
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    settle();

    // one round; hold the digest side so input backs up
    write_rounds(7'd1);
    hold_req = 1'b1;
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b1, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
    settle();

    // zero rounds act as one
    write_rounds(7'd0);
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h20, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b1, 1'b0);
    settle();

    // top of the register range acts as the maximum
    write_rounds(7'h7F);
    send_byte(8'h03, 1'b1, 1'b0);
    settle();

    run_phase(7'd1, 60, 1'b0, 1'b1);
    run_phase(7'($urandom_range(2, 6)), 60, 1'b0, 1'b0);
    run_phase(ROUNDS_MAX, 6, 1'b1, 1'b0);
    run_phase(7'd0, 60, 1'b0, 1'b0);
    run_phase(7'($urandom_range(1, 5)), 60, 1'b0, 1'b0);
    run_phase(7'h7F, 6, 1'b1, 1'b0);
    run_phase(7'd2, 60, 1'b0, 1'b1);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: knot_hash_engine_core.f
rtl/khe_pkg.sv
rtl/khe_ctrl.sv
rtl/khe_datapath.sv
rtl/knot_hash_engine_core.sv
rtl/khe_checker.sv
tb/knot_hash_checker.sv
tb/tb_knot_hash_engine_core.sv
